/* rtl/core/assert_macros.svh */
// Assertion macros shared by the block's RTL files.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define SFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true
`define SFC_ASSERT_NEVER(label, cond, msg) \
	`SFC_ASSERT(label, !(cond), msg)

// Antecedent true implies consequent true in the same cycle
`define SFC_ASSERT_IMPLY(label, ante, cons, msg) \
	`SFC_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* rtl/core/sfc_pkg.sv */
// Shared types, constants and helper functions of the sensor frame decoder.
// No dependencies; compiled first.
package sfc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned TEMP_W    = 15;
	localparam int unsigned HUM_W     = 14;
	localparam int unsigned STAT_W    = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned POS_W     = 3;
	localparam int unsigned TREF_W    = 9;
	localparam int unsigned HREF_W    = 7;

	// Default depth of the frame queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// CRC status codes
	localparam logic [STAT_W-1:0] CRC_OK       = 2'd0;
	localparam logic [STAT_W-1:0] CRC_TEMP_BAD = 2'd1;
	localparam logic [STAT_W-1:0] CRC_HUM_BAD  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT = 1'b1;

	localparam logic [BYTE_W-1:0] CRC_INIT    = 8'hFF;
	localparam logic [BYTE_W-1:0] POLY_RESET  = 8'h31;
	localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd20;

	// Byte positions inside a frame; position zero is also the idle state
	localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
	localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
	localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
	localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
	localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
	localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

	// Scaling constants
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [13:0] HUM_SCALE   = 14'd10000;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;
	localparam logic [12:0] TEMP_OFFSET = 13'd4500;
	localparam logic [12:0] RECIP_100   = 13'd5243;	// ceil(2^19 / 100)
	localparam logic [17:0] CENTI       = 18'd100;

	// Raw words and CRC outcome of one complete frame
	typedef struct packed {
		logic [WORD_W-1:0] raw_t;
		logic [WORD_W-1:0] raw_h;
		logic [STAT_W-1:0] status;
	} frame_rec_t;

	// One byte of CRC-8, MSB first
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] poly);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// floor(m / 100) for any 14-bit m, by reciprocal multiply
	function automatic logic [7:0] div100(input logic [13:0] m);
		logic [26:0] p;
		p = {13'd0, m} * {14'd0, RECIP_100};
		return p[26:19];
	endfunction

endpackage

/* rtl/core/sfc_if.sv */
// Valid/ready channel interfaces: frame bytes in, decoded results out, config writes.
// Depends on sfc_pkg for field widths.
interface sfc_in_if;
	logic                        valid;
	logic                        ready;
	logic [sfc_pkg::BYTE_W-1:0]  rx_byte;
	logic                        frame_start;
	modport source(output valid, rx_byte, frame_start, input ready);
	modport sink(input valid, rx_byte, frame_start, output ready);
endinterface

interface sfc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [sfc_pkg::TEMP_W-1:0]  temperature_centi;
	logic [sfc_pkg::HUM_W-1:0]          humidity_centi;
	logic [sfc_pkg::STAT_W-1:0]         crc_status;
	logic                               temperature_replaced;
	logic                               humidity_replaced;
	modport source(output valid, temperature_centi, humidity_centi, crc_status,
		temperature_replaced, humidity_replaced, input ready);
	modport sink(input valid, temperature_centi, humidity_centi, crc_status,
		temperature_replaced, humidity_replaced, output ready);
endinterface

interface sfc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sfc_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [sfc_pkg::BYTE_W-1:0]     wr_data;
	modport source(output valid, reg_index, wr_data, input ready);
	modport sink(input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/core/sfc_front.sv */
// Front end: tracks byte position, runs the CRC-8 and assembles the raw words.
// Pushes one frame record per complete frame. Depends on sfc_pkg, sfc_if.
`include "assert_macros.svh"

module sfc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	sfc_in_if.sink                      rx,
	input  logic [sfc_pkg::BYTE_W-1:0]  crc_poly,
	input  logic                        q_full,
	output logic                        push_valid,
	output sfc_pkg::frame_rec_t         push_rec
);

	logic [sfc_pkg::POS_W-1:0]   pos_q;
	logic [sfc_pkg::BYTE_W-1:0]  crc_q;
	logic [sfc_pkg::WORD_W-1:0]  tword_q;
	logic [sfc_pkg::WORD_W-1:0]  hword_q;
	logic [sfc_pkg::STAT_W-1:0]  fail_q;

	logic                        accept;
	logic                        active;
	logic [sfc_pkg::POS_W-1:0]   pos_eff;
	logic [sfc_pkg::BYTE_W-1:0]  crc_in;
	logic [sfc_pkg::BYTE_W-1:0]  crc_next;
	logic                        crc_bad;
	logic [sfc_pkg::STAT_W-1:0]  fail_final;

	// Take bytes whenever the queue has room for a finished frame
	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;

	// Frame start restarts; a stray byte while idle is dropped
	assign pos_eff = rx.frame_start ? sfc_pkg::POS_T_HI : pos_q;
	assign active  = rx.frame_start || (pos_q != sfc_pkg::POS_T_HI);

	// CRC datapath
	assign crc_in = (pos_eff == sfc_pkg::POS_T_HI || pos_eff == sfc_pkg::POS_H_HI) ?
		sfc_pkg::CRC_INIT : crc_q;
	assign crc_next = sfc_pkg::crc8_byte(crc_in, rx.rx_byte, crc_poly);
	assign crc_bad  = crc_q != rx.rx_byte;
	assign fail_final = (fail_q == sfc_pkg::CRC_OK && crc_bad) ? sfc_pkg::CRC_HUM_BAD : fail_q;

	// Record of a complete frame; failed frames carry zero words
	assign push_valid = accept && active && (pos_eff == sfc_pkg::POS_H_CRC);
	always_comb begin
		push_rec.status = fail_final;
		push_rec.raw_t  = (fail_final != sfc_pkg::CRC_OK) ? '0 : tword_q;
		push_rec.raw_h  = (fail_final != sfc_pkg::CRC_OK) ? '0 : hword_q;
	end

	// Position, CRC and failure tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= sfc_pkg::POS_T_HI;
			crc_q  <= sfc_pkg::CRC_INIT;
			fail_q <= sfc_pkg::CRC_OK;
		end else if (accept && active) begin
			unique case (pos_eff)
				sfc_pkg::POS_T_HI: begin
					fail_q <= sfc_pkg::CRC_OK;
					crc_q  <= crc_next;
					pos_q  <= sfc_pkg::POS_T_LO;
				end
				sfc_pkg::POS_T_LO: begin
					crc_q <= crc_next;
					pos_q <= sfc_pkg::POS_T_CRC;
				end
				sfc_pkg::POS_T_CRC: begin
					if (crc_bad && fail_q == sfc_pkg::CRC_OK) begin
						fail_q <= sfc_pkg::CRC_TEMP_BAD;
					end
					pos_q <= sfc_pkg::POS_H_HI;
				end
				sfc_pkg::POS_H_HI: begin
					crc_q <= crc_next;
					pos_q <= sfc_pkg::POS_H_LO;
				end
				sfc_pkg::POS_H_LO: begin
					crc_q <= crc_next;
					pos_q <= sfc_pkg::POS_H_CRC;
				end
				sfc_pkg::POS_H_CRC: begin
					fail_q <= fail_final;
					pos_q  <= sfc_pkg::POS_T_HI;
				end
				default: begin
					pos_q <= sfc_pkg::POS_T_HI;
				end
			endcase
		end
	end

	// Word assembly, MSB first
	always_ff @(posedge clk) begin
		if (accept && active) begin
			case (pos_eff)
				sfc_pkg::POS_T_HI: tword_q[15:8] <= rx.rx_byte;
				sfc_pkg::POS_T_LO: tword_q[7:0]  <= rx.rx_byte;
				sfc_pkg::POS_H_HI: hword_q[15:8] <= rx.rx_byte;
				sfc_pkg::POS_H_LO: hword_q[7:0]  <= rx.rx_byte;
				default: ;
			endcase
		end
	end

	`SFC_ASSERT_NEVER(a_pos_range, pos_q > sfc_pkg::POS_H_CRC, "byte position out of range")

endmodule

/* rtl/core/sfc_queue.sv */
// Small frame record queue between the front and back ends.
// Depends on sfc_pkg for the record type.
`include "assert_macros.svh"

module sfc_queue #(
	parameter int unsigned DEPTH = sfc_pkg::QUEUE_DEPTH	// 2 .. 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sfc_pkg::frame_rec_t  push_rec,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output sfc_pkg::frame_rec_t  head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	sfc_pkg::frame_rec_t  mem_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	`SFC_ASSERT_NEVER(a_no_overflow, push && full, "push into full frame queue")
	`SFC_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty frame queue")

endmodule

/* rtl/core/sfc_back.sv */
// Back end: scales raw words to centi units, applies the deglitch references
// and holds the result register. Depends on sfc_pkg, sfc_if.
`include "assert_macros.svh"

module sfc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfc_pkg::frame_rec_t         head,
	input  logic                        empty,
	output logic                        pop,
	input  logic [sfc_pkg::BYTE_W-1:0]  jump_limit,
	sfc_out_if.source                   res
);

	// Stage valids and result register control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic adv;

	// Stage 1: products
	logic [30:0]                 pt_s1;
	logic [29:0]                 ph_s1;
	logic [sfc_pkg::STAT_W-1:0]  st_s1;

	// Stage 2: scaled values
	logic [14:0]                        t_q0, t_quo;
	logic [16:0]                        t_rem;
	logic [13:0]                        h_q0, h_quo;
	logic [16:0]                        h_rem;
	logic signed [sfc_pkg::TEMP_W-1:0]  tc_s2;
	logic [sfc_pkg::HUM_W-1:0]          hc_s2;
	logic [sfc_pkg::STAT_W-1:0]         st_s2;

	// Stage 3: whole units
	logic                               t_neg;
	logic [13:0]                        t_mag;
	logic [7:0]                         t_whole;
	logic [7:0]                         h_whole;
	logic signed [sfc_pkg::TEMP_W-1:0]  tc_s3;
	logic [sfc_pkg::HUM_W-1:0]          hc_s3;
	logic [sfc_pkg::TREF_W-1:0]         tdiv_s3;
	logic [sfc_pkg::HREF_W-1:0]         hdiv_s3;
	logic [sfc_pkg::STAT_W-1:0]         st_s3;

	// Deglitch state and datapath
	logic [sfc_pkg::TREF_W-1:0]  tref_q;
	logic                        tref_valid_q;
	logic [sfc_pkg::HREF_W-1:0]  href_q;
	logic                        href_valid_q;
	logic signed [17:0]          tref100;
	logic signed [17:0]          diff;
	logic [17:0]                 dabs;
	logic [17:0]                 lim100;
	logic [sfc_pkg::HUM_W-1:0]   h100;
	logic                        jump;
	logic                        t_rep, h_rep, tref_set, href_set;

	// Result register drives the output channel
	logic signed [sfc_pkg::TEMP_W-1:0]  temp_q;
	logic [sfc_pkg::HUM_W-1:0]          hum_q;
	logic [sfc_pkg::STAT_W-1:0]         stat_q;
	logic                               t_rep_q, h_rep_q;

	assign res.valid                = out_valid_q;
	assign res.temperature_centi    = temp_q;
	assign res.humidity_centi       = hum_q;
	assign res.crc_status           = stat_q;
	assign res.temperature_replaced = t_rep_q;
	assign res.humidity_replaced    = h_rep_q;

	// Whole pipeline moves unless a result waits at the output
	assign adv = !out_valid_q || res.ready;
	assign pop = adv && !empty;

	// Divide by 65535: q0 = x >> 16, remainder x mod 2^16 + q0 needs one correction
	assign t_q0  = pt_s1[30:16];
	assign t_rem = {1'b0, pt_s1[15:0]} + {2'b0, t_q0};
	assign t_quo = t_q0 + 15'(t_rem >= sfc_pkg::FULL_SCALE);
	assign h_q0  = ph_s1[29:16];
	assign h_rem = {1'b0, ph_s1[15:0]} + {3'b0, h_q0};
	assign h_quo = h_q0 + 14'(h_rem >= sfc_pkg::FULL_SCALE);

	// Truncation toward zero to whole units
	assign t_neg   = tc_s2[sfc_pkg::TEMP_W-1];
	assign t_mag   = t_neg ? 14'(~tc_s2 + 15'd1) : tc_s2[13:0];
	assign t_whole = sfc_pkg::div100(t_mag);
	assign h_whole = sfc_pkg::div100(hc_s2);

	// Deglitch decision
	assign tref100  = {{9{tref_q[sfc_pkg::TREF_W-1]}}, tref_q} * $signed(sfc_pkg::CENTI);
	assign diff     = tref100 - {{3{tc_s3[sfc_pkg::TEMP_W-1]}}, tc_s3};
	assign dabs     = diff[17] ? 18'(-diff) : 18'(diff);
	assign lim100   = {10'd0, jump_limit} * sfc_pkg::CENTI;
	assign jump     = dabs >= lim100;
	assign t_rep    = tref_valid_q && jump;
	assign tref_set = tref_valid_q ? !jump : (tc_s3 != '0);
	assign h100     = {7'd0, href_q} * 14'd100;
	assign h_rep    = href_valid_q && (hc_s3 == '0);
	assign href_set = hc_s3 != '0;

	// Control state: valids and references
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			out_valid_q  <= 1'b0;
			tref_q       <= '0;
			tref_valid_q <= 1'b0;
			href_q       <= '0;
			href_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
			if (v_s3) begin
				if (tref_set) begin
					tref_q       <= tdiv_s3;
					tref_valid_q <= 1'b1;
				end
				if (href_set) begin
					href_q       <= hdiv_s3;
					href_valid_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1   <= {15'd0, head.raw_t} * {16'd0, sfc_pkg::TEMP_SCALE};
			ph_s1   <= {14'd0, head.raw_h} * {16'd0, sfc_pkg::HUM_SCALE};
			st_s1   <= head.status;
			tc_s2   <= $signed(t_quo - {2'b0, sfc_pkg::TEMP_OFFSET});
			hc_s2   <= h_quo;
			st_s2   <= st_s1;
			tc_s3   <= tc_s2;
			hc_s3   <= hc_s2;
			tdiv_s3 <= t_neg ? 9'(-{1'b0, t_whole}) : {1'b0, t_whole};
			hdiv_s3 <= h_whole[sfc_pkg::HREF_W-1:0];
			st_s3   <= st_s2;
			temp_q  <= t_rep ? tref100[sfc_pkg::TEMP_W-1:0] : tc_s3;
			hum_q   <= h_rep ? h100 : hc_s3;
			stat_q  <= st_s3;
			t_rep_q <= t_rep;
			h_rep_q <= h_rep;
		end
	end

	`SFC_ASSERT_IMPLY(a_trep_ref, res.valid && res.temperature_replaced, tref_valid_q,
		"temperature replaced without a reference")
	`SFC_ASSERT_IMPLY(a_hrep_val, res.valid && res.humidity_replaced, res.humidity_centi == h100,
		"replaced humidity differs from its reference")

endmodule

/* rtl/core/sensor_frame_crc_check_and_deglitch.sv */
// Sensor frame decoder top level: config registers, front end, frame queue, back end.
// Depends on sfc_pkg, sfc_if, sfc_front, sfc_queue, sfc_back.
//
// Takes one frame byte per transfer and can accept a byte every cycle. A frame is
// six bytes (temperature word, CRC-8, humidity word, CRC-8), started by frame_start;
// its result passes from the sixth byte into the frame queue, through three scaling
// stages, then the deglitch stage that writes the result register. Input bytes
// stall only when the frame queue (QUEUE_DEPTH records) is full because results
// are not being taken. Configuration writes are always taken and should be issued
// only while no frame is in flight.

module sensor_frame_crc_check_and_deglitch #(
	parameter int unsigned QUEUE_DEPTH = sfc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	sfc_in_if.sink      rx,
	sfc_out_if.source   res,
	sfc_cfg_if.sink     cfg
);

	logic [sfc_pkg::BYTE_W-1:0]  crc_poly_q;
	logic [sfc_pkg::BYTE_W-1:0]  jump_limit_q;
	logic                        q_full, q_empty, q_push, q_pop;
	sfc_pkg::frame_rec_t         push_rec, head_rec;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q   <= sfc_pkg::POLY_RESET;
			jump_limit_q <= sfc_pkg::LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				sfc_pkg::CFG_CRC_POLY:   crc_poly_q   <= cfg.wr_data;
				sfc_pkg::CFG_JUMP_LIMIT: jump_limit_q <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	sfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.crc_poly   (crc_poly_q),
		.q_full     (q_full),
		.push_valid (q_push),
		.push_rec   (push_rec)
	);

	sfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_rec)
	);

	sfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_rec),
		.empty      (q_empty),
		.pop        (q_pop),
		.jump_limit (jump_limit_q),
		.res        (res)
	);

endmodule
